// ===== hdl/spn_pkg.sv =====
package spn_pkg;

    localparam int unsigned NumRounds = 3;

    localparam logic [7:0] MASK_HI = 8'h88;
    localparam logic [7:0] MASK_MH = 8'h44;
    localparam logic [7:0] MASK_ML = 8'h22;
    localparam logic [7:0] MASK_LO = 8'h11;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [NumRounds:0][31:0] t_subkeys;

    localparam logic [7:0] SBOX [256] = '{
        8'h00, 8'h01, 8'h81, 8'h56, 8'hC1, 8'h67, 8'h2B, 8'h93,
        8'hE1, 8'hC8, 8'hB4, 8'hBB, 8'h96, 8'hB2, 8'hCA, 8'h78,
        8'hF1, 8'h79, 8'h64, 8'hE6, 8'h5A, 8'h31, 8'hDE, 8'hBE,
        8'h4B, 8'h48, 8'h59, 8'hEE, 8'h65, 8'hC3, 8'h3C, 8'hC7,
        8'hF9, 8'h94, 8'hBD, 8'hEB, 8'h32, 8'h84, 8'h73, 8'h91,
        8'h2D, 8'hA3, 8'h99, 8'h06, 8'h6F, 8'h28, 8'h5F, 8'hAF,
        8'hA6, 8'h15, 8'h24, 8'h7E, 8'hAD, 8'h61, 8'h77, 8'hF3,
        8'hB3, 8'hF8, 8'hE2, 8'h3D, 8'h1E, 8'h3B, 8'hE4, 8'h66,
        8'hFD, 8'h57, 8'h4A, 8'hEA, 8'hDF, 8'h95, 8'hF6, 8'hB5,
        8'h19, 8'hA9, 8'h42, 8'h18, 8'hBA, 8'hF7, 8'hC9, 8'hF4,
        8'h97, 8'hA5, 8'hD2, 8'h60, 8'hCD, 8'h7F, 8'h03, 8'h41,
        8'hB8, 8'h1A, 8'h14, 8'hD1, 8'hB0, 8'h98, 8'hD8, 8'h2E,
        8'h53, 8'h35, 8'h8B, 8'h87, 8'h12, 8'h1C, 8'h3F, 8'h05,
        8'hD7, 8'hA4, 8'hB1, 8'hF5, 8'hBC, 8'hE0, 8'hFA, 8'h2C,
        8'hDA, 8'h74, 8'h7C, 8'h26, 8'h71, 8'h86, 8'h9F, 8'h36,
        8'h0F, 8'h11, 8'h9E, 8'h8C, 8'h72, 8'hDC, 8'h33, 8'h55,
        8'hFF, 8'h02, 8'hAC, 8'hCE, 8'h25, 8'h8F, 8'h75, 8'h63,
        8'hF0, 8'hF2, 8'hCB, 8'h62, 8'h7B, 8'h90, 8'hDB, 8'h85,
        8'h8D, 8'h27, 8'hD5, 8'h07, 8'h21, 8'h45, 8'h0C, 8'h50,
        8'h5D, 8'h2A, 8'hFC, 8'hC2, 8'hE5, 8'hEF, 8'h7A, 8'h76,
        8'hCC, 8'hAE, 8'hD3, 8'h29, 8'h69, 8'h51, 8'h30, 8'hED,
        8'hE7, 8'h49, 8'hC0, 8'hFE, 8'h82, 8'h34, 8'hA1, 8'h2F,
        8'h5C, 8'h6A, 8'h0D, 8'h38, 8'h0A, 8'h47, 8'hE9, 8'hBF,
        8'h58, 8'hE8, 8'h4C, 8'h0B, 8'h6C, 8'h22, 8'h17, 8'hB7,
        8'hAA, 8'h04, 8'h9B, 8'h1D, 8'hC6, 8'hE3, 8'hC4, 8'h1F,
        8'h09, 8'h4E, 8'h0E, 8'h8A, 8'hA0, 8'h54, 8'h83, 8'hDD,
        8'hEC, 8'h5B, 8'h52, 8'hA2, 8'hD9, 8'h92, 8'hFB, 8'h68,
        8'h5E, 8'hD4, 8'h70, 8'h8E, 8'h7D, 8'hCF, 8'h16, 8'h44,
        8'h6D, 8'h08, 8'h3A, 8'hC5, 8'h3E, 8'h9C, 8'h13, 8'hA8,
        8'hB9, 8'hB6, 8'h43, 8'h23, 8'hD0, 8'hA7, 8'h1B, 8'h9D,
        8'h88, 8'h10, 8'h89, 8'h37, 8'h4F, 8'h6B, 8'h46, 8'h4D,
        8'h39, 8'h20, 8'h6E, 8'hD6, 8'h9A, 8'h40, 8'hAB, 8'h80
    };

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] perm_byte(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] b3);
        return (b0 & MASK_HI) | (b1 & MASK_MH) | (b2 & MASK_ML) | (b3 & MASK_LO);
    endfunction

    function automatic logic [31:0] perm_fwd(input logic [31:0] w);
        logic [7:0] b0, b1, b2, b3;
        b0 = w[7:0];
        b1 = w[15:8];
        b2 = w[23:16];
        b3 = w[31:24];
        return {perm_byte(b3, b0, b1, b2), perm_byte(b2, b3, b0, b1),
                perm_byte(b1, b2, b3, b0), perm_byte(b0, b1, b2, b3)};
    endfunction

    function automatic logic [31:0] perm_inv(input logic [31:0] w);
        logic [7:0] b0, b1, b2, b3;
        b0 = w[7:0];
        b1 = w[15:8];
        b2 = w[23:16];
        b3 = w[31:24];
        return {perm_byte(b3, b2, b1, b0), perm_byte(b2, b1, b0, b3),
                perm_byte(b1, b0, b3, b2), perm_byte(b0, b3, b2, b1)};
    endfunction

endpackage

// ===== hdl/spn_key_sched.sv =====
module spn_key_sched (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [31:0]               i_wr_key,
    output spn_pkg::t_subkeys         o_subkeys
);

    // S-box of each key byte, taken once at the write; round keys are rotations
    logic [31:0] r_sub_key;
    logic [31:0] n_sub_key;

    assign n_sub_key = i_wr_en ? spn_pkg::sub_word(i_wr_key) : r_sub_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_key <= '0;
        end else begin
            r_sub_key <= n_sub_key;
        end
    end

    assign o_subkeys[0] = r_sub_key;
    assign o_subkeys[1] = {r_sub_key[7:0],  r_sub_key[31:8]};
    assign o_subkeys[2] = {r_sub_key[15:0], r_sub_key[31:16]};
    assign o_subkeys[3] = {r_sub_key[23:0], r_sub_key[31:24]};

endmodule

// ===== hdl/spn_core.sv =====
module spn_core (
    input  logic                      i_operation,
    input  logic [31:0]               i_data_word,
    input  logic [31:0]               i_chain_word,
    input  spn_pkg::t_subkeys         i_subkeys,
    output logic [31:0]               o_result_word
);

    logic [31:0] enc_x;
    logic [31:0] dec_x;

    always_comb begin
        enc_x = i_data_word ^ i_chain_word;
        for (int r = 0; r < spn_pkg::NumRounds; r++) begin
            enc_x = spn_pkg::perm_fwd(spn_pkg::sub_word(enc_x ^ i_subkeys[r]));
        end
        enc_x = enc_x ^ i_subkeys[spn_pkg::NumRounds];
    end

    always_comb begin
        dec_x = i_data_word ^ i_subkeys[spn_pkg::NumRounds];
        for (int r = spn_pkg::NumRounds - 1; r >= 0; r--) begin
            dec_x = spn_pkg::sub_word(spn_pkg::perm_inv(dec_x)) ^ i_subkeys[r];
        end
        dec_x = dec_x ^ i_chain_word;
    end

    assign o_result_word = (i_operation == spn_pkg::OP_DECRYPT) ? dec_x : enc_x;

endmodule

// ===== hdl/spn_block_cipher_32bit.sv =====
// Channel  Handshake                  Payload
// in       i_in_valid / o_in_stall    i_operation, i_data_word, i_chain_word
// out      o_out_valid / i_out_stall  o_result_word
// cfg      i_cfg_valid / o_cfg_ready  i_cfg_data (cipher key)
//
// From input beat to result: input register, then the three rounds of S-box
// and permutation in one pass into the result register. One beat per
// cycle unless the output stalls. Synchronous active-low reset clears valids
// and the key (all round keys zero). The input register takes a beat whenever
// it is empty or moving on; a stalled result holds it once it is full.
module spn_block_cipher_32bit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [31:0] i_data_word,
    input  logic [31:0] i_chain_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_result_word
);

    spn_pkg::t_subkeys subkeys;

    logic        r_s1_valid;
    logic        r_s1_op;
    logic [31:0] r_s1_data;
    logic [31:0] r_s1_chain;
    logic        r_out_valid;
    logic [31:0] r_result;

    logic        out_load;
    logic        s1_load;
    logic        n_s1_valid;
    logic        n_out_valid;
    logic [31:0] n_result;

    assign o_cfg_ready = 1'b1;

    spn_key_sched u_key_sched (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (i_cfg_valid),
        .i_wr_key     (i_cfg_data),
        .o_subkeys    (subkeys)
    );

    spn_core u_core (
        .i_operation   (r_s1_op),
        .i_data_word   (r_s1_data),
        .i_chain_word  (r_s1_chain),
        .i_subkeys     (subkeys),
        .o_result_word (n_result)
    );

    assign out_load    = !r_out_valid || !i_out_stall;
    assign s1_load     = !r_s1_valid || out_load;
    assign o_in_stall  = !s1_load;
    assign n_s1_valid  = s1_load ? i_in_valid : r_s1_valid;
    assign n_out_valid = out_load ? r_s1_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) begin
            r_s1_op    <= i_operation;
            r_s1_data  <= i_data_word;
            r_s1_chain <= i_chain_word;
        end
        if (out_load && r_s1_valid) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_word = r_result;

endmodule

// ===== dv/spn_cipher_checker.sv =====
module spn_cipher_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        operation,
    input  logic [31:0] data_word,
    input  logic [31:0] chain_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] result_word,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUNDS = 3;
    localparam logic [7:0] LANE_A = 8'h88;
    localparam logic [7:0] LANE_B = 8'h44;
    localparam logic [7:0] LANE_C = 8'h22;
    localparam logic [7:0] LANE_D = 8'h11;

    localparam logic [7:0] SUBST [256] = '{
        8'h00, 8'h01, 8'h81, 8'h56, 8'hC1, 8'h67, 8'h2B, 8'h93,
        8'hE1, 8'hC8, 8'hB4, 8'hBB, 8'h96, 8'hB2, 8'hCA, 8'h78,
        8'hF1, 8'h79, 8'h64, 8'hE6, 8'h5A, 8'h31, 8'hDE, 8'hBE,
        8'h4B, 8'h48, 8'h59, 8'hEE, 8'h65, 8'hC3, 8'h3C, 8'hC7,
        8'hF9, 8'h94, 8'hBD, 8'hEB, 8'h32, 8'h84, 8'h73, 8'h91,
        8'h2D, 8'hA3, 8'h99, 8'h06, 8'h6F, 8'h28, 8'h5F, 8'hAF,
        8'hA6, 8'h15, 8'h24, 8'h7E, 8'hAD, 8'h61, 8'h77, 8'hF3,
        8'hB3, 8'hF8, 8'hE2, 8'h3D, 8'h1E, 8'h3B, 8'hE4, 8'h66,
        8'hFD, 8'h57, 8'h4A, 8'hEA, 8'hDF, 8'h95, 8'hF6, 8'hB5,
        8'h19, 8'hA9, 8'h42, 8'h18, 8'hBA, 8'hF7, 8'hC9, 8'hF4,
        8'h97, 8'hA5, 8'hD2, 8'h60, 8'hCD, 8'h7F, 8'h03, 8'h41,
        8'hB8, 8'h1A, 8'h14, 8'hD1, 8'hB0, 8'h98, 8'hD8, 8'h2E,
        8'h53, 8'h35, 8'h8B, 8'h87, 8'h12, 8'h1C, 8'h3F, 8'h05,
        8'hD7, 8'hA4, 8'hB1, 8'hF5, 8'hBC, 8'hE0, 8'hFA, 8'h2C,
        8'hDA, 8'h74, 8'h7C, 8'h26, 8'h71, 8'h86, 8'h9F, 8'h36,
        8'h0F, 8'h11, 8'h9E, 8'h8C, 8'h72, 8'hDC, 8'h33, 8'h55,
        8'hFF, 8'h02, 8'hAC, 8'hCE, 8'h25, 8'h8F, 8'h75, 8'h63,
        8'hF0, 8'hF2, 8'hCB, 8'h62, 8'h7B, 8'h90, 8'hDB, 8'h85,
        8'h8D, 8'h27, 8'hD5, 8'h07, 8'h21, 8'h45, 8'h0C, 8'h50,
        8'h5D, 8'h2A, 8'hFC, 8'hC2, 8'hE5, 8'hEF, 8'h7A, 8'h76,
        8'hCC, 8'hAE, 8'hD3, 8'h29, 8'h69, 8'h51, 8'h30, 8'hED,
        8'hE7, 8'h49, 8'hC0, 8'hFE, 8'h82, 8'h34, 8'hA1, 8'h2F,
        8'h5C, 8'h6A, 8'h0D, 8'h38, 8'h0A, 8'h47, 8'hE9, 8'hBF,
        8'h58, 8'hE8, 8'h4C, 8'h0B, 8'h6C, 8'h22, 8'h17, 8'hB7,
        8'hAA, 8'h04, 8'h9B, 8'h1D, 8'hC6, 8'hE3, 8'hC4, 8'h1F,
        8'h09, 8'h4E, 8'h0E, 8'h8A, 8'hA0, 8'h54, 8'h83, 8'hDD,
        8'hEC, 8'h5B, 8'h52, 8'hA2, 8'hD9, 8'h92, 8'hFB, 8'h68,
        8'h5E, 8'hD4, 8'h70, 8'h8E, 8'h7D, 8'hCF, 8'h16, 8'h44,
        8'h6D, 8'h08, 8'h3A, 8'hC5, 8'h3E, 8'h9C, 8'h13, 8'hA8,
        8'hB9, 8'hB6, 8'h43, 8'h23, 8'hD0, 8'hA7, 8'h1B, 8'h9D,
        8'h88, 8'h10, 8'h89, 8'h37, 8'h4F, 8'h6B, 8'h46, 8'h4D,
        8'h39, 8'h20, 8'h6E, 8'hD6, 8'h9A, 8'h40, 8'hAB, 8'h80
    };

    logic [31:0] key_shadow;
    logic [31:0] words_due [$];

    function automatic logic [7:0] lane(input logic [31:0] w, input int n);
        return w[8 * (n % 4) +: 8];
    endfunction

    function automatic logic [31:0] substitute(input logic [31:0] w);
        logic [31:0] r;
        for (int n = 0; n < 4; n++) r[8 * n +: 8] = SUBST[w[8 * n +: 8]];
        return r;
    endfunction

    function automatic logic [31:0] permute(input logic [31:0] w, input bit inverse);
        logic [31:0] r;
        for (int i = 0; i < 4; i++) begin
            r[8 * i +: 8] = (lane(w, i) & LANE_A)
                          | (lane(w, inverse ? i + 3 : i + 1) & LANE_B)
                          | (lane(w, i + 2) & LANE_C)
                          | (lane(w, inverse ? i + 1 : i + 3) & LANE_D);
        end
        return r;
    endfunction

    function automatic logic [31:0] subkey(input logic [31:0] key, input int rnd);
        logic [31:0] r;
        for (int i = 0; i < 4; i++) r[8 * i +: 8] = SUBST[lane(key, i + rnd)];
        return r;
    endfunction

    function automatic logic [31:0] cipher_block(input logic op, input logic [31:0] data,
                                                 input logic [31:0] chain,
                                                 input logic [31:0] key);
        logic [31:0] x;
        if (op == spn_pkg::OP_DECRYPT) begin
            x = data ^ subkey(key, ROUNDS);
            for (int rnd = ROUNDS; rnd > 0; rnd--)
                x = substitute(permute(x, 1'b1)) ^ subkey(key, rnd - 1);
            return x ^ chain;
        end
        x = data ^ chain;
        for (int rnd = 0; rnd < ROUNDS; rnd++)
            x = permute(substitute(x ^ subkey(key, rnd)), 1'b0);
        return x ^ subkey(key, ROUNDS);
    endfunction

    always @(posedge i_clk) begin
        logic [31:0] due;
        if (!i_rst_n) begin
            key_shadow = '0;
            words_due.delete();
            mismatches <= 0;
            pending <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (words_due.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %08h",
                             $time, result_word);
                    mismatches <= mismatches + 1;
                end else begin
                    due = words_due.pop_front();
                    if (result_word !== due) begin
                        $display("%0t: result_word mismatch, expected %08h, got %08h",
                                 $time, due, result_word);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                words_due.push_back(cipher_block(operation, data_word, chain_word,
                                                 key_shadow));
            if (cfg_valid && cfg_ready) key_shadow = cfg_data;
            pending <= words_due.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        operation = spn_pkg::OP_ENCRYPT;
    logic [31:0] data_word = '0;
    logic [31:0] chain_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] result_word;
    int          mismatches;
    int          pending;

    int          stall_mode = 0;
    int          stall_left = 0;
    int unsigned beat_clock = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    spn_block_cipher_32bit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_operation   (operation),
        .i_data_word   (data_word),
        .i_chain_word  (chain_word),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_result_word (result_word)
    );

    spn_cipher_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .data_word   (data_word),
        .chain_word  (chain_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_word (result_word),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // result-side backpressure: none, light, heavy, or a fixed 5-of-8 pattern
    always @(posedge clk) begin
        beat_clock <= beat_clock + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 150);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            3: out_stall <= (beat_clock[2:0] < 3'd5);
            default: out_stall <= 1'b0;
        endcase
    end

    task automatic push_block(input logic op, input logic [31:0] data,
                              input logic [31:0] chain);
        in_valid   <= 1'b1;
        operation  <= op;
        data_word  <= data;
        chain_word <= chain;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_key(input logic [31:0] key);
        cfg_valid <= 1'b1;
        cfg_data  <= key;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 15))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_corners();
        push_block(spn_pkg::OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        push_block(spn_pkg::OP_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
        push_block(spn_pkg::OP_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
        push_block(spn_pkg::OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_block(spn_pkg::OP_ENCRYPT, 32'h0000_0001, 32'h0000_0000);
        push_block(spn_pkg::OP_ENCRYPT, 32'hAAAA_5555, 32'h5555_AAAA);
        push_block(spn_pkg::OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        push_block(spn_pkg::OP_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
        push_block(spn_pkg::OP_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
        push_block(spn_pkg::OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_block(spn_pkg::OP_DECRYPT, 32'h8000_0000, 32'h0000_0001);
        push_block(spn_pkg::OP_DECRYPT, 32'h5555_AAAA, 32'hAAAA_5555);
        drain();
    endtask

    task automatic run_random(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && sent < count; j++) begin
                push_block(1'($urandom_range(0, 1)), random_word(),
                           ($urandom_range(0, 2) == 0) ? 32'h0 : random_word());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 19) == 0) begin
                drain();
            end else if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        drain();
    endtask

    initial begin
        logic [31:0] keys [6];
        keys = '{32'h0000_0000, 32'h0000_0001, 32'h8000_0000,
                 $urandom, $urandom, $urandom};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        run_corners();
        write_key(32'hFFFF_FFFF);
        run_corners();
        foreach (keys[k]) begin
            write_key(keys[k]);
            run_random(88);
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/spn_pkg.sv
hdl/spn_key_sched.sv
hdl/spn_core.sv
hdl/spn_block_cipher_32bit.sv
dv/spn_cipher_checker.sv
dv/testbench.sv
